>>> rtl/arp_ct_pkg.sv
// ----------------------------------------------------------------------------
// arp_ct_pkg
// Shared types and constants of the ARP cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_ct_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    typedef logic [IP_W-1:0]  t_ip;
    typedef logic [MAC_W-1:0] t_mac;

    localparam t_ip  BCAST_IP = '1;
    localparam t_mac BCAST_MAC = '1;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_RESOLVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_BROADCAST = 3'd1,
        ST_MISS      = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_INSERTED  = 3'd4,
        ST_IGNORED   = 3'd5,
        ST_FULL      = 3'd6
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_IP   = 2'd2;

    // Request from the datapath to the table
    typedef struct packed {
        logic upd_en;   // commit an update this cycle
        t_ip  key;      // address to match
        t_mac mac;      // MAC to store on update
    } t_tbl_req;

    // Combinational answer of the table for the current key
    typedef struct packed {
        logic hit;
        logic free_avail;
        t_mac hit_mac;
    } t_tbl_rsp;

endpackage

`default_nettype wire

>>> rtl/arp_ct_req_if.sv
// ----------------------------------------------------------------------------
// arp_ct_req_if
// Request channel: update or resolve item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_ct_req_if;
    logic                  valid;
    logic                  ready;
    logic                  operation;
    arp_ct_pkg::t_ip       ip_addr;
    arp_ct_pkg::t_mac      mac_in;

    modport source (output valid, operation, ip_addr, mac_in, input ready);
    modport sink   (input valid, operation, ip_addr, mac_in, output ready);
endinterface

`default_nettype wire

>>> rtl/arp_ct_rsp_if.sv
// ----------------------------------------------------------------------------
// arp_ct_rsp_if
// Result channel: status, MAC and next hop, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_ct_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [arp_ct_pkg::STATUS_W-1:0]      status;
    arp_ct_pkg::t_mac                     mac_out;
    arp_ct_pkg::t_ip                      next_hop_ip;

    modport source (output valid, status, mac_out, next_hop_ip, input ready);
    modport sink   (input valid, status, mac_out, next_hop_ip, output ready);
endinterface

`default_nettype wire

>>> rtl/arp_ct_table.sv
// ----------------------------------------------------------------------------
// arp_ct_table
// Entry storage with parallel match, first-free search and update write.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ct_table #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire arp_ct_pkg::t_tbl_req i_req,
    output arp_ct_pkg::t_tbl_rsp  o_rsp
);
    import arp_ct_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0] r_valid;
    t_ip                      r_ip  [TABLE_ENTRIES];
    t_mac                     r_mac [TABLE_ENTRIES];

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_avail;
    logic [IDX_W-1:0] free_idx;

    // Descending scan: the lowest index wins
    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_avail = 1'b0;
        free_idx   = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (r_valid[k] && (r_ip[k] == i_req.key)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
            if (!r_valid[k]) begin
                free_avail = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    assign o_rsp.hit        = hit;
    assign o_rsp.free_avail = free_avail;
    assign o_rsp.hit_mac    = r_mac[hit_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.upd_en && !hit && free_avail) begin
            r_valid[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.upd_en) begin
            if (hit) begin
                r_mac[hit_idx] <= i_req.mac;
            end else if (free_avail) begin
                r_ip[free_idx]  <= i_req.key;
                r_mac[free_idx] <= i_req.mac;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/arp_cache_table.sv
// Pipeline: an accepted beat is registered in the input register, then its result
//   is registered in the result register, which drives result valid.
// Throughput: one beat per cycle unless o_rsp.ready stalls; the table is updated
//   on the same edge that loads the result register, so the next beat sees the update.
// Reset: synchronous; clears the valid marks, the config registers and both
//   pipeline valid flags at once. No clearing pass.
// ----------------------------------------------------------------------------
// arp_cache_table
// IPv4 to MAC cache: update, resolve with next-hop selection, miss report.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire [arp_ct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [arp_ct_pkg::CFG_W-1:0]         i_cfg_data,
    arp_ct_req_if.sink                          i_req,
    arp_ct_rsp_if.source                        o_rsp
);
    import arp_ct_pkg::*;

    // Configuration
    t_ip r_own_ip;
    t_ip r_subnet_mask;
    t_ip r_router_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip      <= '0;
            r_subnet_mask <= '0;
            r_router_ip   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_OWN_IP:      r_own_ip      <= i_cfg_data;
                CFG_SUBNET_MASK: r_subnet_mask <= i_cfg_data;
                CFG_ROUTER_IP:   r_router_ip   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic r_in_valid;
    t_op  r_op;
    t_ip  r_ip;
    t_mac r_mac;

    logic r_out_valid;
    logic advance;
    logic in_take;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= t_op'(i_req.operation);
            r_ip  <= i_req.ip_addr;
            r_mac <= i_req.mac_in;
        end
    end

    // Work on the registered beat
    logic     fire;
    logic     on_subnet;
    t_ip      hop;
    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;
    t_status  n_status;
    t_mac     n_mac_out;
    t_ip      n_hop_out;

    assign fire      = r_in_valid && advance;
    assign on_subnet = (r_ip & r_subnet_mask) == (r_own_ip & r_subnet_mask);
    assign hop       = on_subnet ? r_ip : r_router_ip;

    assign tbl_req.upd_en = fire && (r_op == OP_UPDATE) && (r_ip != '0);
    assign tbl_req.key    = (r_op == OP_UPDATE) ? r_ip : hop;
    assign tbl_req.mac    = r_mac;

    arp_ct_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    always_comb begin
        n_mac_out = '0;
        n_hop_out = '0;
        case (r_op)
            OP_UPDATE: begin
                if (r_ip == '0) begin
                    n_status = ST_IGNORED;
                end else if (tbl_rsp.hit) begin
                    n_status = ST_UPDATED;
                end else if (tbl_rsp.free_avail) begin
                    n_status = ST_INSERTED;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_RESOLVE: begin
                if (r_ip == BCAST_IP) begin
                    n_status  = ST_BROADCAST;
                    n_mac_out = BCAST_MAC;
                    n_hop_out = BCAST_IP;
                end else begin
                    n_hop_out = hop;
                    if (tbl_rsp.hit) begin
                        n_status  = ST_HIT;
                        n_mac_out = tbl_rsp.hit_mac;
                    end else begin
                        n_status = ST_MISS;
                    end
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // Result register
    t_status r_status;
    t_mac    r_mac_out;
    t_ip     r_hop_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= n_status;
            r_mac_out <= n_mac_out;
            r_hop_out <= n_hop_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.mac_out     = r_mac_out;
    assign o_rsp.next_hop_ip = r_hop_out;

endmodule

`default_nettype wire

>>> rtl/arp_ct_checker.sv
// ----------------------------------------------------------------------------
// arp_ct_checker
// Port-level checks of the ARP cache table result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ct_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [arp_ct_pkg::STATUS_W-1:0]   i_status,
    input wire [arp_ct_pkg::MAC_W-1:0]      i_mac_out,
    input wire [arp_ct_pkg::IP_W-1:0]       i_next_hop_ip
);
    import arp_ct_pkg::*;

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_BROADCAST)
            |-> (i_mac_out == BCAST_MAC) && (i_next_hop_ip == BCAST_IP))
        else $error("broadcast result without all-ones fields");

    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_status == ST_UPDATED) || (i_status == ST_INSERTED) ||
                        (i_status == ST_IGNORED) || (i_status == ST_FULL))
            |-> (i_mac_out == '0) && (i_next_hop_ip == '0))
        else $error("update result carries non-zero fields");

    a_miss_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_MISS) |-> (i_mac_out == '0))
        else $error("miss result carries a MAC");

endmodule

bind arp_cache_table arp_ct_checker u_arp_ct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_mac_out     (o_rsp.mac_out),
    .i_next_hop_ip (o_rsp.next_hop_ip)
);

`default_nettype wire
